// ===== rtl/imucf_pkg.sv =====
// Shared constants, register codes and fixed-point helpers for the IMU attitude filter.
// Depends on nothing; used by imu_complementary_attitude_filter.
package imucf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int IT_W = 5;

	localparam logic signed [17:0] PI_Q15      = 18'sd102944;
	localparam logic signed [17:0] HALF_PI_Q15 = 18'sd51472;
	localparam logic signed [22:0] TWO_PI_Q15  = 23'sd205887;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] RATE_K      = 32'sd2456333;
	localparam logic signed [16:0] ONE_G       = 17'sd4096;

	typedef enum logic [1:0] {
		CFG_BLEND,
		CFG_DEADBAND,
		CFG_GYRO_LIM,
		CFG_ACCEL_TOL
	} cfg_idx_t;

	function automatic logic signed [27:0] atan_entry(input logic [IT_W-1:0] i);
		case (i)
			5'd0:    return 28'sd13176795;
			5'd1:    return 28'sd7778716;
			5'd2:    return 28'sd4110060;
			5'd3:    return 28'sd2086331;
			5'd4:    return 28'sd1047214;
			5'd5:    return 28'sd524117;
			5'd6:    return 28'sd262123;
			5'd7:    return 28'sd131069;
			5'd8:    return 28'sd65536;
			5'd9:    return 28'sd32768;
			5'd10:   return 28'sd16384;
			5'd11:   return 28'sd8192;
			5'd12:   return 28'sd4096;
			5'd13:   return 28'sd2048;
			5'd14:   return 28'sd1024;
			5'd15:   return 28'sd512;
			5'd16:   return 28'sd256;
			5'd17:   return 28'sd128;
			5'd18:   return 28'sd64;
			5'd19:   return 28'sd32;
			5'd20:   return 28'sd16;
			5'd21:   return 28'sd8;
			5'd22:   return 28'sd4;
			5'd23:   return 28'sd2;
			default: return 28'sd0;
		endcase
	endfunction

	// Round a Q1.30 by Q1.30 product back to Q1.30.
	function automatic logic signed [31:0] r30(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (p + 64'sd536870912) >>> 30;
		return s[31:0];
	endfunction

	// Round Q1.30 to Q2.14 and saturate to plus minus one.
	function automatic logic signed [15:0] q14(input logic signed [32:0] v);
		logic signed [32:0] s;
		s = (v + 33'sd32768) >>> 16;
		if (s > 33'sd16384)
			return 16'sd16384;
		else if (s < -33'sd16384)
			return -16'sd16384;
		return s[15:0];
	endfunction

	// Gyro increment: rounded (hi * 2^20 + lo) / 2^40.
	function automatic logic signed [21:0] r40(input logic signed [63:0] h,
			input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (h <<< 20) + p + (64'sd1 <<< 39);
		return s[61:40];
	endfunction

	// Rounded Q0.16 blend back to Q3.15, saturated to plus minus pi.
	function automatic logic signed [17:0] blend_out(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = (v + 64'sd32768) >>> 16;
		if (s > 64'(PI_Q15))
			return PI_Q15;
		else if (s < -64'(PI_Q15))
			return -PI_Q15;
		return s[17:0];
	endfunction

	// CORDIC angle at 2^-24 rad to Q3.15, saturated to plus minus pi.
	function automatic logic signed [17:0] atan_out(input logic signed [27:0] z);
		logic signed [28:0] s;
		s = (29'(z) + 29'sd256) >>> 9;
		if (s > 29'(PI_Q15))
			return PI_Q15;
		else if (s < -29'(PI_Q15))
			return -PI_Q15;
		return s[17:0];
	endfunction

	function automatic logic signed [19:0] dead(input logic signed [19:0] g,
			input logic [15:0] db);
		logic [19:0] m;
		m = g[19] ? 20'(-g) : 20'(g);
		return (m < {4'b0, db}) ? 20'sd0 : g;
	endfunction

endpackage

// ===== rtl/imu_complementary_attitude_filter.sv =====
// Complementary roll/pitch/yaw filter with ZYX rotation matrix output.
// Depends on imucf_pkg; one shared multiplier, one CORDIC unit, one square root unit.
//
//   channel | direction | payload
//   s_*     | in        | tdata: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, step_time
//   m_*     | out       | tdata: roll, pitch, yaw angles, rot_00 .. rot_22
//   cfg_*   | in        | cfg_index selects register, cfg_data holds the value
//
// The sequencer runs 19 multiplier steps, 26 square root steps, five CORDIC passes of a set-up
// step and CORDIC_STEPS iterations, the blend, the yaw wrap (repeated while yaw lies outside
// plus minus pi) and 15 matrix multiplier steps. A still sample skips the blend multiplies; a
// zero step_time skips all but the three sine/cosine passes and the matrix steps.
// Reset clears the angle state and loads register defaults. A new item is taken once the
// previous one is finished, even while its result still waits on m_tready.
module imu_complementary_attitude_filter
	import imucf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, step_time
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// roll_angle, pitch_angle, yaw_angle, rot_00, rot_01, rot_02, rot_10, rot_11,
	// rot_12, rot_20, rot_21, rot_22, 2 zero bits
	output logic [199:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FRONT, ST_SQRT, ST_ATAN_PREP, ST_ATAN_RUN, ST_BLEND,
		ST_WRAP, ST_SC_PREP, ST_SC_RUN, ST_MATRIX, ST_DONE
	} state_t;

	localparam logic [1:0] AX_ROLL  = 2'd0;
	localparam logic [1:0] AX_PITCH = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	state_t state_q;
	logic [4:0] k_q;
	logic [IT_W-1:0] it_q;
	logic [1:0] sel_q;

	logic [15:0] weight_q, deadband_q;
	logic [17:0] glim_q;
	logic [14:0] atol_q;

	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [19:0] gx_q, gy_q, gz_q;
	logic [19:0] dt_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_q, hk_q;
	logic [40:0] gsq_q;
	logic [35:0] lim2_q;
	logic [31:0] asq_q, ryz_q, lo2_q, hi2_q;
	logic signed [39:0] pdx_q, pdy_q, pdz_q;
	logic signed [21:0] incx_q, incy_q, incz_q;

	logic [51:0] sv_q, sr_q, sb_q;
	logic [4:0] sq_cnt_q;
	logic [52:0] rb;
	logic sq_ge;

	logic signed [31:0] cor_x_q, cor_y_q, xs, ys, x_nx, y_nx, ya, xa;
	logic signed [27:0] cor_z_q, z_nx, tab;
	logic dpos, zero_q, neg_q;

	logic signed [17:0] tilt_roll_q, tilt_pitch_q, roll_q, pitch_q, yaw_q, ang, af;
	logic signed [22:0] yaw_w_q;
	logic signed [31:0] cos_q [3];
	logic signed [31:0] sin_q [3];
	logic signed [31:0] a_q, t_q, m30;
	logic signed [15:0] rot_q [9];

	logic signed [16:0] lo_s;
	logic [16:0] hi_u, wc;
	logic still;

	logic m_tvalid_q;
	logic [199:0] out_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;

	assign lo_s = ONE_G - $signed({2'b0, atol_q});
	assign hi_u = 17'd4096 + {2'b0, atol_q};
	assign wc   = 17'd65536 - {1'b0, weight_q};
	assign still = (gsq_q < {5'b0, lim2_q}) && (lo_s[16] || (asq_q > lo2_q)) &&
		(asq_q < hi2_q);
	assign m30 = r30(prod_q);

	// Shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_FRONT: begin
				case (k_q)
					5'd0:  begin ma = 32'(gx_q); mb = 32'(gx_q); end
					5'd1:  begin ma = 32'(gy_q); mb = 32'(gy_q); end
					5'd2:  begin ma = 32'(gz_q); mb = 32'(gz_q); end
					5'd3:  begin ma = 32'(glim_q); mb = 32'(glim_q); end
					5'd4:  begin ma = 32'(ax_q); mb = 32'(ax_q); end
					5'd5:  begin ma = 32'(ay_q); mb = 32'(ay_q); end
					5'd6:  begin ma = 32'(az_q); mb = 32'(az_q); end
					5'd7:  begin ma = 32'(lo_s); mb = 32'(lo_s); end
					5'd8:  begin ma = 32'(hi_u); mb = 32'(hi_u); end
					5'd9:  begin ma = 32'(gx_q); mb = 32'(dt_q); end
					5'd10: begin ma = 32'(gy_q); mb = 32'(dt_q); end
					5'd11: begin ma = 32'(gz_q); mb = 32'(dt_q); end
					5'd12: begin ma = 32'($signed(pdx_q[39:20])); mb = RATE_K; end
					5'd13: begin ma = 32'({1'b0, pdx_q[19:0]}); mb = RATE_K; end
					5'd14: begin ma = 32'($signed(pdy_q[39:20])); mb = RATE_K; end
					5'd15: begin ma = 32'({1'b0, pdy_q[19:0]}); mb = RATE_K; end
					5'd16: begin ma = 32'($signed(pdz_q[39:20])); mb = RATE_K; end
					5'd17: begin ma = 32'({1'b0, pdz_q[19:0]}); mb = RATE_K; end
					default: ;
				endcase
			end
			ST_BLEND: begin
				case (k_q)
					5'd0: begin ma = 32'(wc); mb = 32'(23'(roll_q) + 23'(incx_q)); end
					5'd1: begin ma = 32'(weight_q); mb = 32'(tilt_roll_q); end
					5'd2: begin ma = 32'(wc); mb = 32'(23'(pitch_q) + 23'(incy_q)); end
					5'd3: begin ma = 32'(weight_q); mb = 32'(tilt_pitch_q); end
					default: ;
				endcase
			end
			ST_MATRIX: begin
				case (k_q)
					5'd0:  begin ma = cos_q[AX_YAW]; mb = cos_q[AX_PITCH]; end
					5'd1:  begin ma = cos_q[AX_YAW]; mb = sin_q[AX_PITCH]; end
					5'd2:  begin ma = sin_q[AX_YAW]; mb = cos_q[AX_ROLL]; end
					5'd3:  begin ma = a_q; mb = sin_q[AX_ROLL]; end
					5'd4:  begin ma = sin_q[AX_YAW]; mb = sin_q[AX_ROLL]; end
					5'd5:  begin ma = a_q; mb = cos_q[AX_ROLL]; end
					5'd6:  begin ma = sin_q[AX_YAW]; mb = cos_q[AX_PITCH]; end
					5'd7:  begin ma = sin_q[AX_YAW]; mb = sin_q[AX_PITCH]; end
					5'd8:  begin ma = cos_q[AX_YAW]; mb = cos_q[AX_ROLL]; end
					5'd9:  begin ma = a_q; mb = sin_q[AX_ROLL]; end
					5'd10: begin ma = cos_q[AX_YAW]; mb = sin_q[AX_ROLL]; end
					5'd11: begin ma = a_q; mb = cos_q[AX_ROLL]; end
					5'd12: begin ma = cos_q[AX_PITCH]; mb = sin_q[AX_ROLL]; end
					5'd13: begin ma = cos_q[AX_PITCH]; mb = cos_q[AX_ROLL]; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Square root step
	always_comb begin
		rb = {1'b0, sr_q} + {1'b0, sb_q};
		sq_ge = ({1'b0, sv_q} >= rb);
	end

	// CORDIC step, vectoring in ST_ATAN_RUN, rotation otherwise
	always_comb begin
		xs = cor_x_q >>> it_q;
		ys = cor_y_q >>> it_q;
		tab = atan_entry(it_q);
		dpos = (state_q == ST_ATAN_RUN) ? !(cor_y_q > 32'sd0) : (cor_z_q >= 28'sd0);
		x_nx = dpos ? cor_x_q - ys : cor_x_q + ys;
		y_nx = dpos ? cor_y_q + xs : cor_y_q - xs;
		z_nx = dpos ? cor_z_q - tab : cor_z_q + tab;
	end

	// CORDIC set-up operands
	always_comb begin
		if (sel_q == AX_ROLL) begin
			ya = 32'($signed({ay_q, 10'b0}));
			xa = 32'($signed({az_q, 10'b0}));
		end else begin
			ya = (-32'(ax_q)) <<< 10;
			xa = 32'({1'b0, sr_q[25:0]});
		end
		case (sel_q)
			AX_ROLL:  ang = roll_q;
			AX_PITCH: ang = pitch_q;
			default:  ang = yaw_q;
		endcase
		if (ang > HALF_PI_Q15)
			af = ang - PI_Q15;
		else if (ang < -HALF_PI_Q15)
			af = ang + PI_Q15;
		else
			af = ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			it_q       <= '0;
			sel_q      <= AX_ROLL;
			sq_cnt_q   <= '0;
			weight_q   <= 16'd1311;
			deadband_q <= 16'd90;
			glim_q     <= 18'd384;
			atol_q     <= 15'd492;
			roll_q     <= '0;
			pitch_q    <= '0;
			yaw_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			prod_q <= 64'(ma) * 64'(mb);

			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BLEND:     weight_q   <= cfg_data[15:0];
					CFG_DEADBAND:  deadband_q <= cfg_data[15:0];
					CFG_GYRO_LIM:  glim_q     <= cfg_data;
					CFG_ACCEL_TOL: atol_q     <= cfg_data[14:0];
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != ST_DONE)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ax_q  <= $signed(s_tdata[15:0]);
						ay_q  <= $signed(s_tdata[31:16]);
						az_q  <= $signed(s_tdata[47:32]);
						gx_q  <= dead($signed(s_tdata[67:48]), deadband_q);
						gy_q  <= dead($signed(s_tdata[87:68]), deadband_q);
						gz_q  <= dead($signed(s_tdata[107:88]), deadband_q);
						dt_q  <= s_tdata[127:108];
						k_q   <= '0;
						sel_q <= AX_ROLL;
						if (s_tdata[127:108] == 20'd0)
							state_q <= ST_SC_PREP;
						else
							state_q <= ST_FRONT;
					end
				end
				ST_FRONT: begin
					case (k_q)
						5'd1:  gsq_q  <= prod_q[40:0];
						5'd2:  gsq_q  <= gsq_q + prod_q[40:0];
						5'd3:  gsq_q  <= gsq_q + prod_q[40:0];
						5'd4:  lim2_q <= prod_q[35:0];
						5'd5:  asq_q  <= prod_q[31:0];
						5'd6: begin
							asq_q <= asq_q + prod_q[31:0];
							ryz_q <= prod_q[31:0];
						end
						5'd7: begin
							asq_q <= asq_q + prod_q[31:0];
							ryz_q <= ryz_q + prod_q[31:0];
						end
						5'd8:  lo2_q  <= prod_q[31:0];
						5'd9:  hi2_q  <= prod_q[31:0];
						5'd10: pdx_q  <= prod_q[39:0];
						5'd11: pdy_q  <= prod_q[39:0];
						5'd12: pdz_q  <= prod_q[39:0];
						5'd13: hk_q   <= prod_q;
						5'd14: incx_q <= r40(hk_q, prod_q);
						5'd15: hk_q   <= prod_q;
						5'd16: incy_q <= r40(hk_q, prod_q);
						5'd17: hk_q   <= prod_q;
						5'd18: incz_q <= r40(hk_q, prod_q);
						default: ;
					endcase
					if (k_q == 5'd18) begin
						sv_q     <= {ryz_q, 20'b0};
						sr_q     <= '0;
						sb_q     <= {2'b01, 50'b0};
						sq_cnt_q <= '0;
						state_q  <= ST_SQRT;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				ST_SQRT: begin
					if (sq_ge) begin
						sv_q <= sv_q - rb[51:0];
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q     <= sb_q >> 2;
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd25) begin
						sel_q   <= AX_ROLL;
						state_q <= ST_ATAN_PREP;
					end
				end
				ST_ATAN_PREP: begin
					zero_q <= (xa == 32'sd0) && (ya == 32'sd0);
					if (xa < 32'sd0) begin
						if (ya >= 32'sd0) begin
							cor_x_q <= ya;
							cor_y_q <= -xa;
							cor_z_q <= HALF_PI_Q24;
						end else begin
							cor_x_q <= -ya;
							cor_y_q <= xa;
							cor_z_q <= -HALF_PI_Q24;
						end
					end else begin
						cor_x_q <= xa;
						cor_y_q <= ya;
						cor_z_q <= '0;
					end
					it_q    <= '0;
					state_q <= ST_ATAN_RUN;
				end
				ST_ATAN_RUN: begin
					cor_x_q <= x_nx;
					cor_y_q <= y_nx;
					cor_z_q <= z_nx;
					it_q    <= it_q + IT_W'(1);
					if (it_q == IT_W'(CORDIC_STEPS - 1)) begin
						if (sel_q == AX_ROLL) begin
							tilt_roll_q <= zero_q ? 18'sd0 : atan_out(z_nx);
							sel_q       <= AX_PITCH;
							state_q     <= ST_ATAN_PREP;
						end else begin
							tilt_pitch_q <= zero_q ? 18'sd0 : atan_out(z_nx);
							k_q          <= '0;
							state_q      <= ST_BLEND;
						end
					end
				end
				ST_BLEND: begin
					if (k_q == 5'd0 && still) begin
						roll_q  <= tilt_roll_q;
						pitch_q <= tilt_pitch_q;
						yaw_w_q <= 23'(yaw_q) + 23'(incz_q);
						state_q <= ST_WRAP;
					end else begin
						case (k_q)
							5'd1: hk_q    <= prod_q;
							5'd2: roll_q  <= blend_out(hk_q + prod_q);
							5'd3: hk_q    <= prod_q;
							5'd4: pitch_q <= blend_out(hk_q + prod_q);
							default: ;
						endcase
						if (k_q == 5'd4) begin
							yaw_w_q <= 23'(yaw_q) + 23'(incz_q);
							state_q <= ST_WRAP;
						end else begin
							k_q <= k_q + 5'd1;
						end
					end
				end
				ST_WRAP: begin
					if (yaw_w_q > 23'(PI_Q15)) begin
						yaw_w_q <= yaw_w_q - TWO_PI_Q15;
					end else if (yaw_w_q < -23'(PI_Q15)) begin
						yaw_w_q <= yaw_w_q + TWO_PI_Q15;
					end else begin
						yaw_q   <= yaw_w_q[17:0];
						sel_q   <= AX_ROLL;
						state_q <= ST_SC_PREP;
					end
				end
				ST_SC_PREP: begin
					neg_q   <= (ang > HALF_PI_Q15) || (ang < -HALF_PI_Q15);
					cor_x_q <= CORDIC_GAIN;
					cor_y_q <= '0;
					cor_z_q <= 28'(af) <<< 9;
					it_q    <= '0;
					state_q <= ST_SC_RUN;
				end
				ST_SC_RUN: begin
					cor_x_q <= x_nx;
					cor_y_q <= y_nx;
					cor_z_q <= z_nx;
					it_q    <= it_q + IT_W'(1);
					if (it_q == IT_W'(CORDIC_STEPS - 1)) begin
						cos_q[sel_q] <= neg_q ? -x_nx : x_nx;
						sin_q[sel_q] <= neg_q ? -y_nx : y_nx;
						if (sel_q == AX_YAW) begin
							k_q     <= '0;
							state_q <= ST_MATRIX;
						end else begin
							sel_q   <= sel_q + 2'd1;
							state_q <= ST_SC_PREP;
						end
					end
				end
				ST_MATRIX: begin
					case (k_q)
						5'd1:  rot_q[0] <= q14(33'(m30));
						5'd2:  a_q      <= m30;
						5'd3:  t_q      <= m30;
						5'd4:  rot_q[1] <= q14(33'(m30) - 33'(t_q));
						5'd5:  t_q      <= m30;
						5'd6:  rot_q[2] <= q14(33'(m30) + 33'(t_q));
						5'd7:  rot_q[3] <= q14(33'(m30));
						5'd8:  a_q      <= m30;
						5'd9:  t_q      <= m30;
						5'd10: rot_q[4] <= q14(33'(m30) + 33'(t_q));
						5'd11: t_q      <= m30;
						5'd12: rot_q[5] <= q14(33'(m30) - 33'(t_q));
						5'd13: rot_q[7] <= q14(33'(m30));
						5'd14: begin
							rot_q[8] <= q14(33'(m30));
							rot_q[6] <= q14(-33'(sin_q[AX_PITCH]));
						end
						default: ;
					endcase
					if (k_q == 5'd14)
						state_q <= ST_DONE;
					else
						k_q <= k_q + 5'd1;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						out_q <= {2'b0, rot_q[8], rot_q[7], rot_q[6], rot_q[5], rot_q[4],
							rot_q[3], rot_q[2], rot_q[1], rot_q[0], yaw_q, pitch_q, roll_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
